FILE: sv/first_match_policy_rule_table_defines.svh
// ----------------------------------------------------------------------------
// first_match_policy_rule_table_defines.svh
// Assertion macros shared by the policy rule table checkers.
// ----------------------------------------------------------------------------
`ifndef FIRST_MATCH_POLICY_RULE_TABLE_DEFINES_SVH
`define FIRST_MATCH_POLICY_RULE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FMPRT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fmprt assertion failed");

// Next-cycle implication, disabled during reset.
`define FMPRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fmprt assertion failed");

`endif

FILE: sv/fmprt_pkg.sv
// ----------------------------------------------------------------------------
// fmprt_pkg
// Types and codes of the first-match policy rule table.
// ----------------------------------------------------------------------------
package fmprt_pkg;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [1:0] ACT_ALLOW = 2'd0;
  localparam logic [1:0] ACT_DENY  = 2'd1;
  localparam logic [1:0] ACT_AUDIT = 2'd2;

  // One stored rule; also the payload of an incoming transfer.
  typedef struct packed {
    logic [1:0] action;
    logic       dst_any;
    logic [7:0] dst;
    logic       src_any;
    logic [7:0] src;
    logic [2:0] kind;
  } rule_t;

  typedef struct packed {
    logic       audit_event;
    logic       rule_matched;
    logic [1:0] decision;
    logic       add_status;
  } result_t;

  localparam int RULE_W = $bits(rule_t);

endpackage

FILE: sv/first_match_policy_rule_table.sv
// ----------------------------------------------------------------------------
// first_match_policy_rule_table
// First-match zone access rule table with wildcards, deny by default.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one transfer per request. s_tuser[0] is the opcode
//   (0 add rule, 1 check). An add appends the rule to the table; a full
//   table drops it and reports add_status 1. A check between equal zones is
//   allowed at once; otherwise rules are searched in insertion order and the
//   first hit decides, with deny plus an audit flag when nothing hits.
//   Output stream m_*: exactly one result transfer per input transfer.
// Sequencing:
//   An add, a same-zone check and a check on an empty table go straight to
//   the sequencer's result register, then to the output register. Other
//   checks first scan the rule RAM from entry 0 up to the first hit, or
//   through all stored rules when nothing hits, before the result is
//   registered. The rule RAM read port fetches one entry per cycle.
//   One request is in flight at a time; a new one is taken once the prior
//   result has moved into the output register, even while that waits.
// Reset: rule count cleared, both streams empty. RAM contents are not cleared;
//   only entries below the count are ever used.
// Stall: a held m_tvalid keeps m_tdata; the sequencer waits with its result
//   and s_tready stays low until the output register frees.
// ----------------------------------------------------------------------------
module first_match_policy_rule_table #(
  parameter int RULE_SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  // [2:0] operation_kind, [10:3] source_zone, [11] source_any,
  // [19:12] dest_zone, [20] dest_any, [22:21] rule_action, [23] zero
  input  logic [23:0] s_tdata,
  // [0] opcode
  input  logic [0:0] s_tuser,
  output logic       m_tvalid,
  input  logic       m_tready,
  // [0] add_status, [2:1] decision, [3] rule_matched, [4] audit_event,
  // [7:5] zero
  output logic [7:0] m_tdata
);
  import fmprt_pkg::*;

  localparam int ADDR_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

  rule_t              in_rule;
  result_t            res;
  result_t            out_res;
  logic               res_valid;
  logic               res_ready;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [RULE_W-1:0]  ram_wdata;
  logic [RULE_W-1:0]  ram_rdata;

  assign in_rule = rule_t'(s_tdata[RULE_W-1:0]);

  fmprt_scan #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_opcode (s_tuser[0]),
    .in_rule   (in_rule),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // rule storage: written by adds, read one entry per scan cycle
  fmprt_ram #(
    .WIDTH (RULE_W),
    .DEPTH (RULE_SLOTS)
  ) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res};

endmodule

FILE: sv/fmprt_ram.sv
// ----------------------------------------------------------------------------
// fmprt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fmprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/fmprt_scan.sv
// ----------------------------------------------------------------------------
// fmprt_scan
// Sequencer: appends rules and scans the rule RAM one entry per cycle.
// ----------------------------------------------------------------------------
module fmprt_scan #(
  parameter int RULE_SLOTS = 64,
  localparam int ADDR_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1,
  localparam int CNT_W  = $clog2(RULE_SLOTS + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  fmprt_pkg::rule_t           in_rule,
  output logic                       res_valid,
  input  logic                       res_ready,
  output fmprt_pkg::result_t         res,
  output logic                       ram_we,
  output logic [ADDR_W-1:0]          ram_waddr,
  output logic [fmprt_pkg::RULE_W-1:0] ram_wdata,
  output logic [ADDR_W-1:0]          ram_raddr,
  input  logic [fmprt_pkg::RULE_W-1:0] ram_rdata
);
  import fmprt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] used, used_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [2:0]       req_kind, req_kind_next;
  logic [7:0]       req_src, req_src_next;
  logic [7:0]       req_dst, req_dst_next;
  result_t          res_next;

  rule_t            entry;
  rule_t            new_rule;
  logic             full;
  logic             hit;
  logic             last;
  logic [CNT_W-1:0] idx_inc;

  assign entry   = rule_t'(ram_rdata);
  assign full    = (used == CNT_W'(RULE_SLOTS));
  assign idx_inc = CNT_W'(idx) + CNT_W'(1);
  assign last    = (idx_inc == used);
  assign hit     = (entry.kind == req_kind)
                && (entry.src_any || entry.src == req_src)
                && (entry.dst_any || entry.dst == req_dst);

  always_comb begin
    new_rule = in_rule;
    // undefined action code is stored as deny
    if (in_rule.action > ACT_AUDIT) begin
      new_rule.action = ACT_DENY;
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_HOLD);
  assign ram_wdata = new_rule;
  assign ram_waddr = used[ADDR_W-1:0];

  always_comb begin
    state_next    = state;
    used_next     = used;
    idx_next      = idx;
    req_kind_next = req_kind;
    req_src_next  = req_src;
    req_dst_next  = req_dst;
    res_next      = res;
    ram_we        = 1'b0;
    ram_raddr     = '0;
    case (state)
      ST_IDLE: begin
        idx_next      = '0;
        req_kind_next = in_rule.kind;
        req_src_next  = in_rule.src;
        req_dst_next  = in_rule.dst;
        if (in_valid) begin
          res_next   = '0;
          state_next = ST_HOLD;
          if (in_opcode == OP_ADD) begin
            if (full) begin
              res_next.add_status = 1'b1;
            end else begin
              ram_we    = 1'b1;
              used_next = used + CNT_W'(1);
            end
          end else if (in_rule.src == in_rule.dst) begin
            res_next.decision = ACT_ALLOW;
          end else if (used == '0) begin
            res_next.decision    = ACT_DENY;
            res_next.audit_event = 1'b1;
          end else begin
            // entry 0 is read now, data arrives in the first scan cycle
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = ADDR_W'(idx_inc);
        idx_next  = ADDR_W'(idx_inc);
        if (hit) begin
          res_next.decision     = entry.action;
          res_next.rule_matched = 1'b1;
          res_next.audit_event  = (entry.action == ACT_AUDIT);
          state_next            = ST_HOLD;
        end else if (last) begin
          res_next.decision    = ACT_DENY;
          res_next.audit_event = 1'b1;
          state_next           = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
    end
    idx      <= idx_next;
    req_kind <= req_kind_next;
    req_src  <= req_src_next;
    req_dst  <= req_dst_next;
    res      <= res_next;
  end

endmodule

FILE: sv/fmprt_checker.sv
// ----------------------------------------------------------------------------
// fmprt_checker
// Port-level checks of the policy rule table, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_match_policy_rule_table_defines.svh"

module fmprt_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import fmprt_pkg::*;

  // a stalled result holds
  `FMPRT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one request in flight: no accept right after an accept
  `FMPRT_ASSERT_NEXT(a_one_inflight, clk, rst, s_tvalid && s_tready, !s_tready)

  // audit flag only on audit hit or default deny, never on allow
  `FMPRT_ASSERT_SAME(a_audit_kind, clk, rst, m_tvalid && m_tdata[4], m_tdata[2:1] != ACT_ALLOW)

  // an unmatched non-allow check is the default deny, which audits
  `FMPRT_ASSERT_SAME(a_default_deny, clk, rst, m_tvalid && !m_tdata[3] && m_tdata[2:1] != ACT_ALLOW, m_tdata[4] && m_tdata[2:1] == ACT_DENY)

endmodule

bind first_match_policy_rule_table fmprt_checker u_fmprt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
